[rtl/mstrk_pkg.sv]
// Shared types, event codes and the event decoder of the multitouch slot tracker.
// No dependencies; used by mstrk_slot_store and multitouch_slot_event_tracker_core.
package mstrk_pkg;

    localparam int NUM_SLOTS_DEF = 32;
    localparam int MAX_REPORT    = 32;
    localparam int VALUE_W       = 32;
    localparam int TYPE_W        = 5;
    localparam int CODE_W        = 10;
    localparam int SLOT_IDX_W    = 5;
    localparam int SLOTS_USE_W   = 6;
    localparam int CFG_DATA_W    = 6;
    localparam int S_TDATA_W     = 48;
    localparam int M_TDATA_W     = 232;

    localparam logic CFG_MT_MODE      = 1'b0;
    localparam logic CFG_SLOTS_IN_USE = 1'b1;

    localparam logic [TYPE_W-1:0] EV_SYN = 5'd0;
    localparam logic [TYPE_W-1:0] EV_KEY = 5'd1;
    localparam logic [TYPE_W-1:0] EV_ABS = 5'd3;

    localparam logic [CODE_W-1:0] SYN_REPORT       = 10'h000;
    localparam logic [CODE_W-1:0] CODE_X           = 10'h000;
    localparam logic [CODE_W-1:0] CODE_Y           = 10'h001;
    localparam logic [CODE_W-1:0] CODE_PRESSURE    = 10'h018;
    localparam logic [CODE_W-1:0] CODE_MT_SLOT     = 10'h02f;
    localparam logic [CODE_W-1:0] CODE_MT_MAJOR    = 10'h030;
    localparam logic [CODE_W-1:0] CODE_MT_MINOR    = 10'h031;
    localparam logic [CODE_W-1:0] CODE_MT_ORIENT   = 10'h034;
    localparam logic [CODE_W-1:0] CODE_MT_POS_X    = 10'h035;
    localparam logic [CODE_W-1:0] CODE_MT_POS_Y    = 10'h036;
    localparam logic [CODE_W-1:0] CODE_MT_TRACK_ID = 10'h039;
    localparam logic [CODE_W-1:0] CODE_MT_PRESSURE = 10'h03a;
    localparam logic [CODE_W-1:0] CODE_TOOL_FIRST  = 10'h140;
    localparam logic [CODE_W-1:0] CODE_TOOL_LAST   = 10'h14f;
    localparam logic [CODE_W-1:0] CODE_KEY_TOUCH   = 10'h14a;

    localparam logic [VALUE_W-1:0] TRACK_NONE = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        FLD_X,
        FLD_Y,
        FLD_PRESSURE,
        FLD_MAJOR,
        FLD_MINOR,
        FLD_ORIENT,
        FLD_TRACK
    } slot_field_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_SCAN_RD
    } trk_state_t;

    typedef struct packed {
        logic [VALUE_W-1:0] track;
        logic [VALUE_W-1:0] orient;
        logic [VALUE_W-1:0] minor;
        logic [VALUE_W-1:0] major;
        logic [VALUE_W-1:0] pressure;
        logic [VALUE_W-1:0] pos_y;
        logic [VALUE_W-1:0] pos_x;
    } slot_row_t;

    localparam slot_row_t ROW_RESET = '{
        track:    TRACK_NONE,
        orient:   '0,
        minor:    '0,
        major:    '0,
        pressure: '0,
        pos_y:    '0,
        pos_x:    '0
    };

    typedef struct packed {
        logic        report;
        logic        slot_sel;
        logic        update;
        logic        set_active;
        logic        use_code;
        slot_field_t field;
    } ev_decode_t;

    function automatic ev_decode_t decode_event(
        logic              mt_mode,
        logic [TYPE_W-1:0] ev_type,
        logic [CODE_W-1:0] ev_code
    );
        ev_decode_t d;
        d = '0;
        d.field = FLD_X;
        unique case (ev_type)
            EV_SYN: begin
                d.report = (ev_code == SYN_REPORT);
            end
            EV_ABS: begin
                if (ev_code == CODE_MT_SLOT) begin
                    d.slot_sel = 1'b1;
                end else if (ev_code == CODE_MT_TRACK_ID) begin
                    d.update     = 1'b1;
                    d.set_active = 1'b1;
                    d.field      = FLD_TRACK;
                end else begin
                    d.update = 1'b1;
                    if (!mt_mode && ev_code == CODE_X) begin
                        d.field = FLD_X;
                    end else if (!mt_mode && ev_code == CODE_Y) begin
                        d.field = FLD_Y;
                    end else if (!mt_mode && ev_code == CODE_PRESSURE) begin
                        d.field = FLD_PRESSURE;
                    end else if (ev_code == CODE_MT_MAJOR) begin
                        d.field = FLD_MAJOR;
                    end else if (ev_code == CODE_MT_MINOR) begin
                        d.field = FLD_MINOR;
                    end else if (ev_code == CODE_MT_ORIENT) begin
                        d.field = FLD_ORIENT;
                    end else if (ev_code == CODE_MT_POS_X) begin
                        d.field = FLD_X;
                    end else if (ev_code == CODE_MT_POS_Y) begin
                        d.field = FLD_Y;
                    end else if (ev_code == CODE_MT_PRESSURE) begin
                        d.field = FLD_PRESSURE;
                    end else begin
                        d.update = 1'b0;
                    end
                end
            end
            EV_KEY: begin
                if (!mt_mode && ev_code >= CODE_TOOL_FIRST && ev_code <= CODE_TOOL_LAST
                    && ev_code != CODE_KEY_TOUCH) begin
                    d.update   = 1'b1;
                    d.use_code = 1'b1;
                    d.field    = FLD_TRACK;
                end
            end
            default: begin
            end
        endcase
        return d;
    endfunction

endpackage

[rtl/multitouch_slot_event_tracker_core.sv]
// Top level of the multitouch slot tracker: event decode, slot state and frame report scan.
// Depends on mstrk_pkg and mstrk_slot_store.
//
//  channel  | signals                          | item
//  ---------+----------------------------------+-------------------------------------
//  s_       | s_tvalid s_tready s_tdata        | one input event (type, code, value)
//  m_       | m_tvalid m_tready m_tdata m_tlast| one active slot of a reported frame
//  cfg_     | cfg_wr_en cfg_index cfg_wdata    | register write, no handshake
//
// Slot select, sync and ignored events are done on acceptance; axis, tracking id and tool key
// events then read the slot row from the slot memory and write it back.
// A report walks min(slots_in_use, NUM_SLOTS, 32) slots: an inactive slot is skipped, an
// active slot is read from memory and then loaded into the output register, and the scan then
// returns to idle; the next slot is not read while a result waits on m_tready.
// aresetn is synchronous; all slot rows read as reset until first written, no clearing pass.
// s_tready is low while a row update or a report scan is in progress.
module multitouch_slot_event_tracker_core #(
    parameter int NUM_SLOTS = mstrk_pkg::NUM_SLOTS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic                                 cfg_index,
    input  logic [mstrk_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // event_type [4:0], event_code [14:5], event_value [46:15], zero [47]
    input  logic [mstrk_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // slot_index [4:0], pos_x [36:5], pos_y [68:37], pressure [100:69],
    // size_major [132:101], size_minor [164:133], orientation [196:165],
    // tracking_id [228:197], zero [231:229]
    output logic [mstrk_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                 m_tlast
);

    localparam int SW       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SCAN_MAX = (NUM_SLOTS < mstrk_pkg::MAX_REPORT) ? NUM_SLOTS
                                                                   : mstrk_pkg::MAX_REPORT;
    localparam int CW       = $clog2(SCAN_MAX + 1);
    localparam int M_PAD    = mstrk_pkg::M_TDATA_W - mstrk_pkg::SLOT_IDX_W
                              - $bits(mstrk_pkg::slot_row_t);

    logic [mstrk_pkg::TYPE_W-1:0]  ev_type;
    logic [mstrk_pkg::CODE_W-1:0]  ev_code;
    logic [mstrk_pkg::VALUE_W-1:0] ev_value;
    mstrk_pkg::ev_decode_t         dec;

    mstrk_pkg::trk_state_t            state_reg, state_next;
    logic                             mode_reg;
    logic [mstrk_pkg::SLOTS_USE_W-1:0] siu_reg;
    logic [SW-1:0]                    cur_slot_reg, cur_slot_next;
    logic                             inval_reg, inval_next;
    logic [NUM_SLOTS-1:0]             active_reg, active_next;
    logic [CW-1:0]                    idx_reg, idx_next;
    mstrk_pkg::slot_field_t           upd_field_reg, upd_field_next;
    logic [mstrk_pkg::VALUE_W-1:0]    upd_value_reg, upd_value_next;
    logic                             m_valid_reg, m_valid_next;
    logic                             m_last_reg, m_last_next;
    mstrk_pkg::slot_row_t             m_row_reg, m_row_next;
    logic [mstrk_pkg::SLOT_IDX_W-1:0] m_idx_reg, m_idx_next;

    logic                 rd_en;
    logic [SW-1:0]        rd_addr;
    mstrk_pkg::slot_row_t rd_row;
    logic                 wr_en;
    mstrk_pkg::slot_row_t wr_row;

    logic [CW-1:0]        lim;
    logic [NUM_SLOTS-1:0] act_vec;
    logic                 later_act;
    logic [SW-1:0]        idx_sel;

    assign ev_type  = s_tdata[4:0];
    assign ev_code  = s_tdata[14:5];
    assign ev_value = s_tdata[46:15];
    assign dec      = mstrk_pkg::decode_event(mode_reg, ev_type, ev_code);
    assign idx_sel  = idx_reg[SW-1:0];

    assign lim = (32'(siu_reg) > SCAN_MAX) ? CW'(SCAN_MAX) : CW'(siu_reg);

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            act_vec[i] = active_reg[i] || (!mode_reg && i == 0);
        end
    end

    always_comb begin
        later_act = 1'b0;
        for (int i = 0; i < SCAN_MAX; i++) begin
            if (act_vec[i] && CW'(i) > idx_reg && CW'(i) < lim) begin
                later_act = 1'b1;
            end
        end
    end

    mstrk_slot_store #(
        .NUM_SLOTS (NUM_SLOTS),
        .SW        (SW)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_row  (rd_row),
        .wr_en   (wr_en),
        .wr_addr (cur_slot_reg),
        .wr_row  (wr_row)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b1;
            siu_reg  <= mstrk_pkg::SLOTS_USE_W'(mstrk_pkg::MAX_REPORT);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mstrk_pkg::CFG_MT_MODE:      mode_reg <= cfg_wdata[0];
                mstrk_pkg::CFG_SLOTS_IN_USE: siu_reg  <= cfg_wdata[mstrk_pkg::SLOTS_USE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mstrk_pkg::ST_IDLE;
            cur_slot_reg <= '0;
            inval_reg    <= 1'b0;
            active_reg   <= '0;
            idx_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_slot_reg <= cur_slot_next;
            inval_reg    <= inval_next;
            active_reg   <= active_next;
            idx_reg      <= idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        upd_field_reg <= upd_field_next;
        upd_value_reg <= upd_value_next;
        m_last_reg    <= m_last_next;
        m_row_reg     <= m_row_next;
        m_idx_reg     <= m_idx_next;
    end

    always_comb begin
        state_next     = state_reg;
        cur_slot_next  = cur_slot_reg;
        inval_next     = inval_reg;
        active_next    = active_reg;
        idx_next       = idx_reg;
        upd_field_next = upd_field_reg;
        upd_value_next = upd_value_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_last_next    = m_last_reg;
        m_row_next     = m_row_reg;
        m_idx_next     = m_idx_reg;
        rd_en          = 1'b0;
        rd_addr        = cur_slot_reg;
        wr_en          = 1'b0;
        wr_row         = rd_row;
        s_tready       = (state_reg == mstrk_pkg::ST_IDLE);

        unique case (state_reg)
            mstrk_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (dec.report) begin
                        idx_next   = '0;
                        state_next = mstrk_pkg::ST_SCAN;
                    end else if (dec.slot_sel) begin
                        if (ev_value < 32'(NUM_SLOTS)) begin
                            cur_slot_next = ev_value[SW-1:0];
                            inval_next    = 1'b0;
                        end else begin
                            inval_next = 1'b1;
                        end
                    end else if (dec.update && !inval_reg) begin
                        if (dec.set_active) begin
                            active_next[cur_slot_reg] = (ev_value != mstrk_pkg::TRACK_NONE);
                        end
                        upd_field_next = dec.field;
                        upd_value_next = dec.use_code ? mstrk_pkg::VALUE_W'(ev_code) : ev_value;
                        rd_en          = 1'b1;
                        state_next     = mstrk_pkg::ST_UPDATE;
                    end
                end
            end
            mstrk_pkg::ST_UPDATE: begin
                wr_en = 1'b1;
                case (upd_field_reg)
                    mstrk_pkg::FLD_X:        wr_row.pos_x    = upd_value_reg;
                    mstrk_pkg::FLD_Y:        wr_row.pos_y    = upd_value_reg;
                    mstrk_pkg::FLD_PRESSURE: wr_row.pressure = upd_value_reg;
                    mstrk_pkg::FLD_MAJOR:    wr_row.major    = upd_value_reg;
                    mstrk_pkg::FLD_MINOR:    wr_row.minor    = upd_value_reg;
                    mstrk_pkg::FLD_ORIENT:   wr_row.orient   = upd_value_reg;
                    default:                 wr_row.track    = upd_value_reg;
                endcase
                state_next = mstrk_pkg::ST_IDLE;
            end
            mstrk_pkg::ST_SCAN: begin
                if (idx_reg >= lim) begin
                    state_next = mstrk_pkg::ST_IDLE;
                end else if (!act_vec[idx_sel]) begin
                    idx_next = idx_reg + CW'(1);
                end else if (!m_valid_reg || m_tready) begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_sel;
                    state_next = mstrk_pkg::ST_SCAN_RD;
                end
            end
            mstrk_pkg::ST_SCAN_RD: begin
                m_valid_next = 1'b1;
                m_row_next   = rd_row;
                m_idx_next   = mstrk_pkg::SLOT_IDX_W'(idx_reg);
                m_last_next  = !later_act;
                idx_next     = idx_reg + CW'(1);
                state_next   = mstrk_pkg::ST_SCAN;
            end
            default: begin
                state_next = mstrk_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{M_PAD{1'b0}}, m_row_reg, m_idx_reg};

endmodule

[rtl/mstrk_slot_store.sv]
// Per-slot row memory (axes and tracking id) with registered read.
// Row valid bits stand in for the reset contents; depends on mstrk_pkg.
module mstrk_slot_store #(
    parameter int NUM_SLOTS = mstrk_pkg::NUM_SLOTS_DEF,
    parameter int SW        = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rd_en,
    input  logic [SW-1:0]       rd_addr,
    output mstrk_pkg::slot_row_t rd_row,
    input  logic                wr_en,
    input  logic [SW-1:0]       wr_addr,
    input  mstrk_pkg::slot_row_t wr_row
);

    mstrk_pkg::slot_row_t slot_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] written_reg;
    logic [NUM_SLOTS-1:0] written_next;
    mstrk_pkg::slot_row_t rd_data_reg;
    logic                 rd_written_reg;

    always_comb begin
        written_next = written_reg;
        if (wr_en) begin
            written_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else begin
            written_reg <= written_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg    <= slot_mem[rd_addr];
            rd_written_reg <= written_reg[rd_addr];
        end
    end

    assign rd_row = rd_written_reg ? rd_data_reg : mstrk_pkg::ROW_RESET;

endmodule
